>>> rtl/tcw_pkg.sv
// Package for the text console writer: field widths, character codes,
// operation codes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

	// Default screen geometry
	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	// Fixed field widths
	localparam int POS_W  = 11;
	localparam int BYTE_W = 8;
	localparam int OP_W   = 3;
	localparam int CELL_W = 16;

	// Character codes and attribute
	localparam logic [BYTE_W-1:0] CH_NL      = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h0f;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
	localparam logic [OP_W-1:0] OP_NL    = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
	localparam logic [OP_W-1:0] OP_SET   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;

	// Register index of the text attribute
	localparam logic REG_ATTR = 1'b0;

	// Cell counter commands
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_ZERO = 2'd1;
	localparam logic [1:0] CNT_INC  = 2'd2;

	// Cursor commands
	localparam logic [2:0] CUR_HOLD  = 3'd0;
	localparam logic [2:0] CUR_SET   = 3'd1;
	localparam logic [2:0] CUR_INC   = 3'd2;
	localparam logic [2:0] CUR_NL    = 3'd3;
	localparam logic [2:0] CUR_UP    = 3'd4;
	localparam logic [2:0] CUR_ZERO  = 3'd5;
	localparam logic [2:0] CUR_CLAMP = 3'd6;

	// Store write source
	localparam logic [1:0] WR_NONE = 2'd0;
	localparam logic [1:0] WR_INIT = 2'd1;
	localparam logic [1:0] WR_FILL = 2'd2;
	localparam logic [1:0] WR_PUT  = 2'd3;

	// Store read source
	localparam logic [1:0] RD_NONE = 2'd0;
	localparam logic [1:0] RD_COPY = 2'd1;
	localparam logic [1:0] RD_CELL = 2'd2;

	typedef struct packed {
		logic       in_load;
		logic [1:0] cnt_op;
		logic [2:0] cur_op;
		logic [1:0] wsel;
		logic [1:0] rd_sel;
		logic       nl_inc;
		logic       scr_set;
		logic       rd_capture;
		logic       out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ch_zero;
		logic            ch_nl;
		logic            cur_end;
		logic            nl_le_cur;
		logic            nl_end;
		logic            ci_ok;
		logic            cnt_last_copy;
		logic            cnt_last;
		logic            out_free;
	} ctl_sts_t;

endpackage

>>> rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/tcw_datapath.sv
// Datapath of the text console writer: request registers, cursor, row seek,
// cell counter, screen store with copy pipeline, and the result register.
// Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

module tcw_datapath
	import tcw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	output ctl_sts_t          sts,
	input  logic [BYTE_W-1:0] attr,
	input  logic [OP_W-1:0]   in_op,
	input  logic [BYTE_W-1:0] in_char,
	input  logic [POS_W-1:0]  in_new_cursor,
	input  logic [POS_W-1:0]  in_cell_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [POS_W-1:0]  out_cursor,
	output logic [BYTE_W-1:0] out_char,
	output logic [BYTE_W-1:0] out_attr,
	output logic              out_scrolled
);

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int NW    = $clog2(CELLS + COLS + 1);
	localparam int XW    = (NW > POS_W) ? NW : POS_W;

	// Request registers
	logic [OP_W-1:0]   op_q;
	logic [BYTE_W-1:0] ch_q;
	logic [POS_W-1:0]  nc_q;
	logic [POS_W-1:0]  ci_q;

	// Cursor, seek and counter state
	logic [NW-1:0] cursor_q;
	logic [NW-1:0] nl_q;
	logic [AW-1:0] cnt_q;
	logic          scr_q;
	logic [BYTE_W-1:0] rch_q;
	logic [BYTE_W-1:0] rat_q;

	// Copy pipeline: read issued one cycle, write the next
	logic          cp_vld_s1;
	logic [AW-1:0] cp_dst_s1;

	// Store ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Result register
	logic              out_valid_q;
	logic [POS_W-1:0]  out_cursor_q;
	logic [BYTE_W-1:0] out_char_q;
	logic [BYTE_W-1:0] out_attr_q;
	logic              out_scr_q;

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			op_q <= in_op;
			ch_q <= in_char;
			nc_q <= in_new_cursor;
			ci_q <= in_cell_index;
		end
	end

	// Cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else begin
			case (cmd.cur_op)
				CUR_HOLD:  cursor_q <= cursor_q;
				CUR_SET:   cursor_q <= (XW'(nc_q) > XW'(CELLS)) ? NW'(CELLS) : NW'(nc_q);
				CUR_INC:   cursor_q <= cursor_q + NW'(1);
				CUR_NL:    cursor_q <= nl_q;
				CUR_UP:    cursor_q <= (cursor_q >= NW'(COLS)) ? cursor_q - NW'(COLS) : '0;
				CUR_ZERO:  cursor_q <= '0;
				CUR_CLAMP: cursor_q <= (cursor_q > NW'(CELLS)) ? NW'(CELLS) : cursor_q;
				default:   cursor_q <= cursor_q;
			endcase
		end
	end

	// Start of the next row, found by stepping one row per cycle
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			nl_q <= NW'(COLS);
		end else if (cmd.nl_inc) begin
			nl_q <= nl_q + NW'(COLS);
		end
	end

	// Cell counter for fill and copy sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_HOLD: cnt_q <= cnt_q;
				CNT_ZERO: cnt_q <= '0;
				CNT_INC:  cnt_q <= cnt_q + AW'(1);
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	// Per-request result fields
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			scr_q <= 1'b0;
			rch_q <= '0;
			rat_q <= '0;
		end else begin
			if (cmd.scr_set) begin
				scr_q <= 1'b1;
			end
			if (cmd.rd_capture) begin
				rch_q <= ram_rdata[BYTE_W-1:0];
				rat_q <= ram_rdata[CELL_W-1:BYTE_W];
			end
		end
	end

	// Copy pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_vld_s1 <= 1'b0;
		end else begin
			cp_vld_s1 <= (cmd.rd_sel == RD_COPY);
		end
	end

	always_ff @(posedge clk) begin
		cp_dst_s1 <= cnt_q;
	end

	// Read address
	always_comb begin
		case (cmd.rd_sel)
			RD_COPY: ram_raddr = cnt_q + AW'(COLS);
			RD_CELL: ram_raddr = AW'(ci_q);
			default: ram_raddr = cnt_q;
		endcase
	end

	// Write port: a pending copy write goes first
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {attr, CH_SPACE};
		if (cp_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_dst_s1;
			ram_wdata = ram_rdata;
		end else begin
			case (cmd.wsel)
				WR_INIT: begin
					ram_we    = 1'b1;
					ram_wdata = {RESET_ATTR, CH_SPACE};
				end
				WR_FILL: begin
					ram_we    = 1'b1;
				end
				WR_PUT: begin
					ram_we    = 1'b1;
					ram_waddr = AW'(cursor_q);
					ram_wdata = {attr, ch_q};
				end
				default: begin
					ram_we    = 1'b0;
				end
			endcase
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_cursor_q <= POS_W'(cursor_q);
			out_char_q   <= rch_q;
			out_attr_q   <= rat_q;
			out_scr_q    <= scr_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_cursor   = out_cursor_q;
	assign out_char     = out_char_q;
	assign out_attr     = out_attr_q;
	assign out_scrolled = out_scr_q;

	// Status to the controller
	always_comb begin
		sts.op            = op_q;
		sts.ch_zero       = (ch_q == '0);
		sts.ch_nl         = (ch_q == CH_NL);
		sts.cur_end       = (cursor_q >= NW'(CELLS));
		sts.nl_le_cur     = (nl_q <= cursor_q);
		sts.nl_end        = (nl_q >= NW'(CELLS));
		sts.ci_ok         = (XW'(ci_q) < XW'(CELLS));
		sts.cnt_last_copy = (cnt_q == AW'(CELLS - COLS - 1));
		sts.cnt_last      = (cnt_q == AW'(CELLS - 1));
		sts.out_free      = !out_valid_q || out_ready;
	end

endmodule

>>> rtl/tcw_ctrl.sv
// Controller of the text console writer: sequences reset clear, put, newline,
// scroll, clear, set-cursor and read requests by commands to the datapath.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISPATCH = 4'd2;
	localparam logic [3:0] S_SEEK     = 4'd3;
	localparam logic [3:0] S_COPY     = 4'd4;
	localparam logic [3:0] S_DRAIN    = 4'd5;
	localparam logic [3:0] S_FILLROW  = 4'd6;
	localparam logic [3:0] S_POST     = 4'd7;
	localparam logic [3:0] S_CLEAR    = 4'd8;
	localparam logic [3:0] S_RDWAIT   = 4'd9;
	localparam logic [3:0] S_RESP     = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.cnt_op     = CNT_HOLD;
		cmd.cur_op     = CUR_HOLD;
		cmd.wsel       = WR_NONE;
		cmd.rd_sel     = RD_NONE;
		case (state_q)
			// Sweep the store to spaces after reset
			S_INIT: begin
				cmd.wsel   = WR_INIT;
				cmd.cnt_op = CNT_INC;
				if (sts.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_PUT: begin
						if (sts.ch_zero) begin
							state_d = S_RESP;
						end else if (sts.cur_end) begin
							cmd.scr_set = 1'b1;
							cmd.cnt_op  = CNT_ZERO;
							state_d     = S_COPY;
						end else begin
							state_d = S_POST;
						end
					end
					OP_NL: begin
						state_d = S_SEEK;
					end
					OP_CLEAR: begin
						cmd.cnt_op = CNT_ZERO;
						state_d    = S_CLEAR;
					end
					OP_SET: begin
						cmd.cur_op = CUR_SET;
						state_d    = S_RESP;
					end
					OP_READ: begin
						if (sts.ci_ok) begin
							cmd.rd_sel = RD_CELL;
							state_d    = S_RDWAIT;
						end else begin
							state_d = S_RESP;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			// Step row by row to the start of the next row
			S_SEEK: begin
				if (sts.nl_le_cur) begin
					cmd.nl_inc = 1'b1;
				end else begin
					cmd.cur_op = CUR_NL;
					if (sts.op == OP_NL && sts.nl_end) begin
						cmd.scr_set = 1'b1;
						cmd.cnt_op  = CNT_ZERO;
						state_d     = S_COPY;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			// Scroll: move rows up, one cell per cycle
			S_COPY: begin
				cmd.rd_sel = RD_COPY;
				cmd.cnt_op = CNT_INC;
				if (sts.cnt_last_copy) begin
					state_d = S_DRAIN;
				end
			end
			// Last copy write lands here; cursor moves up one row
			S_DRAIN: begin
				cmd.cur_op = CUR_UP;
				state_d    = S_FILLROW;
			end
			S_FILLROW: begin
				cmd.wsel   = WR_FILL;
				cmd.cnt_op = CNT_INC;
				if (sts.cnt_last) begin
					state_d = S_POST;
				end
			end
			// Continue the request after a possible scroll
			S_POST: begin
				if (sts.op == OP_PUT) begin
					if (sts.ch_nl) begin
						state_d = S_SEEK;
					end else begin
						cmd.wsel   = WR_PUT;
						cmd.cur_op = CUR_INC;
						state_d    = S_RESP;
					end
				end else begin
					cmd.cur_op = CUR_CLAMP;
					state_d    = S_RESP;
				end
			end
			S_CLEAR: begin
				cmd.wsel   = WR_FILL;
				cmd.cnt_op = CNT_INC;
				if (sts.cnt_last) begin
					cmd.cur_op = CUR_ZERO;
					state_d    = S_RESP;
				end
			end
			S_RDWAIT: begin
				cmd.rd_capture = 1'b1;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/text_console_writer_top.sv
// Top level of the text console writer: stream ports, APB attribute register,
// controller and datapath. Depends on tcw_pkg, tcw_ctrl, tcw_datapath, tcw_ram.
`timescale 1ns / 1ps

// Text-mode console engine over a COLS x ROWS screen store (cells of char and
// attribute). Requests enter on the s_axis channel (op in tuser), and every
// request gives one result on m_axis: cursor after the request, read cell,
// scroll flag. The attribute used for written characters and spaces is set
// over the APB port at byte address 0 (reset 0x0f).
// A newline steps row by row to the next row start in the row seek; a scroll,
// which a put or a newline can cause, moves the rows up through the store,
// one cell per cycle, and a clear writes one cell per cycle.
// One request is in work at a time; s_axis_tready is high only when the
// controller is idle. The next request is accepted while the last result
// still waits in the output register.
// After reset the store is swept to spaces, one cell a cycle, and no request
// is accepted before that ends; APB writes are taken.
// A stall of m_axis holds the result; a following result waits for it.

module text_console_writer_top
	import tcw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] char_code, [18:8] new_cursor, [29:19] cell_index, [31:30] zero
	input  logic [31:0] s_axis_tdata,
	// [2:0] op
	input  logic [2:0]  s_axis_tuser,
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [10:0] cursor_pos, [18:11] read_char, [26:19] read_attr, [27] scrolled,
	// [31:28] zero
	output logic [31:0] m_axis_tdata,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CELLS = COLS * ROWS;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	logic [BYTE_W-1:0] attr_q;
	logic              in_ready;
	logic [POS_W-1:0]  out_cursor;
	logic [BYTE_W-1:0] out_char;
	logic [BYTE_W-1:0] out_attr;
	logic              out_scrolled;

	// Attribute register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ATTR)) begin
			attr_q <= pwdata[BYTE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_ATTR) ? {24'd0, attr_q} : 32'd0;

	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tcw_datapath #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.attr         (attr_q),
		.in_op        (s_axis_tuser),
		.in_char      (s_axis_tdata[7:0]),
		.in_new_cursor(s_axis_tdata[18:8]),
		.in_cell_index(s_axis_tdata[29:19]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_cursor   (out_cursor),
		.out_char     (out_char),
		.out_attr     (out_attr),
		.out_scrolled (out_scrolled)
	);

	assign s_axis_tready = in_ready;
	assign m_axis_tdata  = {4'd0, out_scrolled, out_attr, out_char, out_cursor};

	// A request, once taken, closes the input until its work is done
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while one is in work");

	// Cursor never reported beyond the past-end value
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(out_cursor) <= 32'(CELLS)))
		else $error("cursor beyond screen end");

	// A scrolling request is never a read
	a_scroll_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_scrolled) |-> (out_char == '0 && out_attr == '0))
		else $error("scroll result carries read data");

endmodule
